// ===== rtl/rc4_stream_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// shared property forms for the cipher's concurrent checks, clocked on clk
// and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// condition in a cycle implies another condition in the same cycle
`define RC4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4 check failed: same-cycle implication");

// condition in a cycle implies another condition in the next cycle
`define RC4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 check failed: next-cycle implication");

`endif

// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4 package
// shared constants, item kinds, controller states and the command and
// status structs between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

	localparam int PERM_SIZE  = 256;
	localparam int PERM_IDX_W = $clog2(PERM_SIZE);
	localparam int KEY_DEPTH  = 256;
	localparam int KEY_IDX_W  = $clog2(KEY_DEPTH);
	localparam int KEY_LEN_W  = 9;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = KEY_LEN_W'(16);
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(KEY_DEPTH);
	localparam int ITEM_W     = 24;
	localparam int BYTE_W     = 8;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_SCHED = 2'd1,
		KIND_CRYPT = 2'd2
	} rc4_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K_RD,
		ST_K_SUM,
		ST_K_WRN,
		ST_K_WRJ,
		ST_C_RDJ,
		ST_C_WRI,
		ST_C_OUT
	} rc4_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_KEY_WR,
		OP_SCHED_INIT,
		OP_K_RD,
		OP_K_SUM,
		OP_K_WRN,
		OP_K_WRJ,
		OP_C_START,
		OP_C_RDJ,
		OP_C_WRI,
		OP_C_OUT
	} rc4_op_t;

	typedef struct packed {
		rc4_op_t op;
	} rc4_cmd_t;

	typedef struct packed {
		logic sched_last;
		logic out_stall;
	} rc4_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4 controller
// sequences key loads, the key schedule steps and the crypt steps, and
// issues one datapath command per cycle, none while the output step is held
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic [1:0]       item_kind,
	input  wire rc4_pkg::rc4_stat_t stat,
	output rc4_pkg::rc4_cmd_t     cmd
);

	rc4_pkg::rc4_state_t state_q;
	rc4_pkg::rc4_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.op     = rc4_pkg::OP_NONE;
		item_ready = 1'b0;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (item_kind)
						rc4_pkg::KIND_LOAD: begin
							cmd.op = rc4_pkg::OP_KEY_WR;
						end
						rc4_pkg::KIND_SCHED: begin
							cmd.op  = rc4_pkg::OP_SCHED_INIT;
							state_d = rc4_pkg::ST_K_RD;
						end
						rc4_pkg::KIND_CRYPT: begin
							cmd.op  = rc4_pkg::OP_C_START;
							state_d = rc4_pkg::ST_C_RDJ;
						end
						default: begin
							// unused kind is dropped
							cmd.op = rc4_pkg::OP_NONE;
						end
					endcase
				end
			end
			rc4_pkg::ST_K_RD: begin
				cmd.op  = rc4_pkg::OP_K_RD;
				state_d = rc4_pkg::ST_K_SUM;
			end
			rc4_pkg::ST_K_SUM: begin
				cmd.op  = rc4_pkg::OP_K_SUM;
				state_d = rc4_pkg::ST_K_WRN;
			end
			rc4_pkg::ST_K_WRN: begin
				cmd.op  = rc4_pkg::OP_K_WRN;
				state_d = rc4_pkg::ST_K_WRJ;
			end
			rc4_pkg::ST_K_WRJ: begin
				cmd.op  = rc4_pkg::OP_K_WRJ;
				state_d = stat.sched_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
			end
			rc4_pkg::ST_C_RDJ: begin
				cmd.op  = rc4_pkg::OP_C_RDJ;
				state_d = rc4_pkg::ST_C_WRI;
			end
			rc4_pkg::ST_C_WRI: begin
				cmd.op  = rc4_pkg::OP_C_WRI;
				state_d = rc4_pkg::ST_C_OUT;
			end
			rc4_pkg::ST_C_OUT: begin
				// hold here until the output register can take the result
				if (!stat.out_stall) begin
					cmd.op  = rc4_pkg::OP_C_OUT;
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rc4_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rc4_datapath.sv =====
// ----------------------------------------------------------------------------
// rc4 datapath
// permutation memory with per-entry valid bits (invalid reads as identity),
// key store memory, cipher indices, schedule counters and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rc4_pkg::rc4_cmd_t             cmd,
	output rc4_pkg::rc4_stat_t                 stat,
	input  wire logic [rc4_pkg::ITEM_W-1:0]    item_data,
	input  wire logic                          item_last,
	input  wire logic                          cfg_valid,
	input  wire logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rc4_pkg::BYTE_W-1:0]         out_data,
	output logic                               out_last
);

	localparam int PW = rc4_pkg::PERM_IDX_W;
	localparam int KW = rc4_pkg::KEY_IDX_W;
	localparam int LW = rc4_pkg::KEY_LEN_W;
	localparam int BW = rc4_pkg::BYTE_W;

	logic [BW-1:0] perm_mem [0:rc4_pkg::PERM_SIZE-1];
	logic [BW-1:0] key_mem  [0:rc4_pkg::KEY_DEPTH-1];

	logic [rc4_pkg::PERM_SIZE-1:0] pvld_q;
	logic [BW-1:0] perm_rd_q;
	logic          rd_vld_q;
	logic [PW-1:0] rd_addr_q;
	logic [BW-1:0] key_rd_q;

	logic [PW-1:0] i_q, j_q, n_q;
	logic [KW-1:0] k_q;
	logic [LW-1:0] key_len_q;
	logic [BW-1:0] si_q, sj_q, data_q;
	logic          last_q;
	logic          out_valid_q;
	logic [BW-1:0] out_data_q;
	logic          out_last_q;

	logic          perm_rd_en, perm_wr_en;
	logic [PW-1:0] perm_rd_addr, perm_wr_addr;
	logic [BW-1:0] perm_wr_data;
	logic [BW-1:0] s_rd;
	logic [BW-1:0] ks;
	logic [LW-1:0] eff_len;
	logic [KW:0]   k_inc;
	logic          key_wr_en;
	logic [BW-1:0] key_index;
	logic [BW-1:0] key_byte;
	logic [BW-1:0] data_byte;

	assign key_index = item_data[BW-1:0];
	assign key_byte  = item_data[2*BW-1:BW];
	assign data_byte = item_data[3*BW-1:2*BW];

	// an entry never written since the last schedule or reset reads as its own index
	assign s_rd = rd_vld_q ? perm_rd_q : rd_addr_q;

	// keystream entry after the swap: the two swapped places are forwarded
	always_comb begin
		if (rd_addr_q == i_q) begin
			ks = sj_q;
		end else if (rd_addr_q == j_q) begin
			ks = si_q;
		end else begin
			ks = s_rd;
		end
	end

	assign eff_len = (key_len_q == '0 || key_len_q > rc4_pkg::KEY_LEN_MAX)
		? rc4_pkg::KEY_LEN_MAX : key_len_q;
	assign k_inc = {1'b0, k_q} + (KW+1)'(1);

	assign key_wr_en = (cmd.op == rc4_pkg::OP_KEY_WR) &&
		({1'b0, key_index} < (BW+1)'(rc4_pkg::KEY_DEPTH));

	always_comb begin
		perm_rd_en   = 1'b0;
		perm_rd_addr = '0;
		perm_wr_en   = 1'b0;
		perm_wr_addr = '0;
		perm_wr_data = '0;
		case (cmd.op)
			rc4_pkg::OP_K_RD: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = n_q;
			end
			rc4_pkg::OP_K_SUM: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = j_q + key_rd_q + s_rd;
			end
			rc4_pkg::OP_K_WRN: begin
				perm_wr_en   = 1'b1;
				perm_wr_addr = n_q;
				perm_wr_data = s_rd;
			end
			rc4_pkg::OP_K_WRJ: begin
				perm_wr_en   = 1'b1;
				perm_wr_addr = j_q;
				perm_wr_data = si_q;
			end
			rc4_pkg::OP_C_START: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = i_q + PW'(1);
			end
			rc4_pkg::OP_C_RDJ: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = j_q + s_rd;
			end
			rc4_pkg::OP_C_WRI: begin
				perm_rd_en   = 1'b1;
				perm_rd_addr = si_q + s_rd;
				perm_wr_en   = 1'b1;
				perm_wr_addr = i_q;
				perm_wr_data = s_rd;
			end
			rc4_pkg::OP_C_OUT: begin
				perm_wr_en   = 1'b1;
				perm_wr_addr = j_q;
				perm_wr_data = si_q;
			end
			default: begin
				perm_rd_en = 1'b0;
			end
		endcase
	end

	// permutation memory, registered read of old data
	always_ff @(posedge clk) begin
		if (perm_wr_en) begin
			perm_mem[perm_wr_addr] <= perm_wr_data;
		end
		if (perm_rd_en) begin
			perm_rd_q <= perm_mem[perm_rd_addr];
			rd_addr_q <= perm_rd_addr;
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[key_index[KW-1:0]] <= key_byte;
		end
		if (cmd.op == rc4_pkg::OP_K_RD) begin
			key_rd_q <= key_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (perm_rd_en) begin
				rd_vld_q <= pvld_q[perm_rd_addr];
			end
			if (cmd.op == rc4_pkg::OP_SCHED_INIT) begin
				pvld_q <= '0;
			end else if (perm_wr_en) begin
				pvld_q[perm_wr_addr] <= 1'b1;
			end
		end
	end

	// indices, counters and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			key_len_q <= rc4_pkg::KEY_LEN_RST;
		end else begin
			if (cfg_valid) begin
				key_len_q <= cfg_data;
			end
			case (cmd.op)
				rc4_pkg::OP_SCHED_INIT: begin
					i_q <= '0;
					j_q <= '0;
					n_q <= '0;
					k_q <= '0;
				end
				rc4_pkg::OP_K_SUM: begin
					j_q <= j_q + key_rd_q + s_rd;
				end
				rc4_pkg::OP_K_WRJ: begin
					n_q <= n_q + PW'(1);
					k_q <= (LW'(k_inc) >= eff_len) ? '0 : k_inc[KW-1:0];
					if (stat.sched_last) begin
						j_q <= '0;
					end
				end
				rc4_pkg::OP_C_START: begin
					i_q <= i_q + PW'(1);
				end
				rc4_pkg::OP_C_RDJ: begin
					j_q <= j_q + s_rd;
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == rc4_pkg::OP_C_START) begin
			data_q <= data_byte;
			last_q <= item_last;
		end
		if (cmd.op == rc4_pkg::OP_K_SUM || cmd.op == rc4_pkg::OP_C_RDJ) begin
			si_q <= s_rd;
		end
		if (cmd.op == rc4_pkg::OP_C_WRI) begin
			sj_q <= s_rd;
		end
		if (cmd.op == rc4_pkg::OP_C_OUT) begin
			out_data_q <= data_q ^ ks;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == rc4_pkg::OP_C_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.sched_last = (n_q == PW'(rc4_pkg::PERM_SIZE - 1));
	assign stat.out_stall  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4 stream cipher
// byte-wise rc4 engine with key store, key schedule and crypt steps
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  s_axis   | s_axis_tvalid/tready   | tdata 24b, tuser 2b kind, tlast
//  m_axis   | m_axis_tvalid/tready   | tdata 8b, tlast
//  cfg      | cfg_valid/cfg_ready    | cfg_data 9b key_length
//
//  key load: written in idle; crypt byte: start, read-j, write-i and output
//  steps, bound by the single read and single write port of the permutation
//  memory (three dependent reads, swap); key schedule: init, then four memory steps per entry
//  reset leaves the permutation at identity through cleared valid bits
//  a crypt item holds in its last step while the output register is full
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// key_index [7:0], key_byte [15:8], data_byte [23:16]
	input  wire logic [23:0] s_axis_tdata,
	// kind [1:0]
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_byte [7:0]
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  cfg_data
);

	rc4_pkg::rc4_cmd_t  cmd;
	rc4_pkg::rc4_stat_t stat;

	assign cfg_ready = 1'b1;

	rc4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_ready (s_axis_tready),
		.item_kind  (s_axis_tuser),
		.stat       (stat),
		.cmd        (cmd)
	);

	rc4_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item_data (s_axis_tdata),
		.item_last (s_axis_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

`include "rc4_stream_cipher_assert.svh"

	// a result is never written over one still waiting
	`RC4_ASSERT_SAME(a_no_overwrite, cmd.op == rc4_pkg::OP_C_OUT, !stat.out_stall)
	// an accepted crypt item goes straight into its swap steps
	`RC4_ASSERT_NEXT(a_crypt_flow,
		s_axis_tvalid && s_axis_tready && s_axis_tuser == rc4_pkg::KIND_CRYPT,
		cmd.op == rc4_pkg::OP_C_RDJ)
	// the last schedule step returns to taking items
	`RC4_ASSERT_NEXT(a_sched_end, cmd.op == rc4_pkg::OP_K_WRJ && stat.sched_last,
		s_axis_tready)

endmodule

`default_nettype wire
